FILE: sv/ptt_pkg.sv
// Periodic timer table: shared types, codes and constants.
// Used by ptt_cell, ptt_ctrl and the periodic_timer_table_unit top level; depends on nothing.
package ptt_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int ID_BITS_DEF     = 8;
  localparam int ID_FIELD_W      = 8;   // handler_id and fired_id on the ports
  localparam int TIME_W          = 32;
  localparam int ACT_W           = 3;
  localparam int STAT_W          = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK   = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_START  = 3'd3,
    ACT_STOP   = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 3'd0,
    STAT_FULL  = 3'd1,
    STAT_MISS  = 3'd2,
    STAT_FIRED = 3'd3,
    STAT_NONE  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SWEEP  = 2'd1,
    S_FINISH = 2'd2
  } ctrl_state_e;

  // Request fields broadcast to every cell while its token walks the chain.
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] now;
  } cmd_t;

endpackage

FILE: sv/ptt_cell.sv
// One slot of the timer table: holds an entry and acts on it when the token is here.
// Depends on ptt_pkg; instantiated in a chain by periodic_timer_table_unit.
module ptt_cell #(
  parameter int ID_BITS = ptt_pkg::ID_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,      // move token, commit updates
  input  ptt_pkg::cmd_t             cmd_i,
  input  logic [ID_BITS-1:0]        cmd_id_i,
  input  logic                      tok_i,      // token from left neighbor
  input  logic                      found_i,
  input  logic                      used_r_i,   // right neighbor's entry
  input  logic [ID_BITS-1:0]        id_r_i,
  input  logic [ptt_pkg::TIME_W-1:0] period_r_i,
  input  logic [ptt_pkg::TIME_W-1:0] last_r_i,
  input  logic                      en_r_i,
  output logic                      tok_o,
  output logic                      found_o,
  output logic                      fire_o,
  output logic                      used_o,
  output logic [ID_BITS-1:0]        id_o,
  output logic [ptt_pkg::TIME_W-1:0] period_o,
  output logic [ptt_pkg::TIME_W-1:0] last_o,
  output logic                      en_o
);
  import ptt_pkg::*;

  logic              tok_q, found_q, used_q, en_q;
  logic [ID_BITS-1:0] id_q;
  logic [TIME_W-1:0] period_q, last_q, elapsed;
  logic              match, hit, shift;

  assign elapsed = cmd_i.now - last_q;
  assign match   = used_q && (id_q == cmd_id_i);

  always_comb begin
    hit = 1'b0;
    case (cmd_i.action) inside
      ACT_ADD:                         hit = tok_q && !found_q && !used_q;
      ACT_REMOVE, ACT_START, ACT_STOP: hit = tok_q && !found_q && match;
      default:                         hit = 1'b0;
    endcase
  end

  assign shift  = tok_q && (cmd_i.action == ACT_REMOVE) && (found_q || hit);
  assign fire_o = tok_q && (cmd_i.action == ACT_TICK) && used_q && en_q &&
                  (elapsed >= period_q);
  assign found_o = found_q || hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= 1'b0;
      found_q <= 1'b0;
      used_q  <= 1'b0;
    end else if (adv_i) begin
      tok_q   <= tok_i;
      found_q <= found_i;
      if (shift) begin
        used_q <= used_r_i;
      end else if (hit && (cmd_i.action == ACT_ADD)) begin
        used_q <= 1'b1;
      end
    end
  end

  // Payload: no reset, read only where used_q is set.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (shift) begin
        id_q     <= id_r_i;
        period_q <= period_r_i;
        last_q   <= last_r_i;
        en_q     <= en_r_i;
      end else if (hit && (cmd_i.action == ACT_ADD)) begin
        id_q     <= cmd_id_i;
        period_q <= cmd_i.period;
        last_q   <= cmd_i.now;
        en_q     <= 1'b1;
      end else if (hit) begin
        en_q <= (cmd_i.action == ACT_START);
      end else if (fire_o) begin
        last_q <= cmd_i.now;
      end
    end
  end

  assign tok_o    = tok_q;
  assign used_o   = used_q;
  assign id_o     = id_q;
  assign period_o = period_q;
  assign last_o   = last_q;
  assign en_o     = en_q;

endmodule

FILE: sv/ptt_ctrl.sv
// Request intake, sweep sequencing and result register for the timer table.
// Depends on ptt_pkg; drives the token and command into the ptt_cell chain.
module ptt_ctrl #(
  parameter int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF,
  parameter int ID_BITS     = ptt_pkg::ID_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [71:0]                   s_axis_tdata,
  input  logic [ptt_pkg::ACT_W-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ptt_pkg::ID_FIELD_W-1:0] m_axis_tdata,
  output logic [ptt_pkg::STAT_W-1:0]    m_axis_tuser,
  output logic                          m_axis_tlast,
  output ptt_pkg::cmd_t                 cmd_o,
  output logic [ID_BITS-1:0]            cmd_id_o,
  output logic                          adv_o,
  output logic                          launch_o,
  input  logic [TIMER_SLOTS-1:0]        fire_i,
  input  logic [ID_BITS-1:0]            cell_id_i [TIMER_SLOTS],
  input  logic                          tok_last_i,
  input  logic                          found_last_i
);
  import ptt_pkg::*;

  localparam int WideW = (ID_BITS > ID_FIELD_W) ? ID_BITS : ID_FIELD_W;

  ctrl_state_e        state_q, state_d;
  cmd_t               cmd_q;
  logic [ID_BITS-1:0] cmd_id_q;
  logic               pend_valid_q, pend_valid_d;
  logic [ID_BITS-1:0] pend_id_q, pend_id_d, fire_id;
  logic               fin_found_q, fin_found_d;
  logic               out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [STAT_W-1:0]  out_stat_q, out_stat_d;
  logic [ID_BITS-1:0] out_id_q, out_id_d;
  logic [WideW-1:0]   in_id_wide, out_id_wide;
  logic               s_accept, out_load, fire_any, stall;

  assign s_accept   = s_axis_tvalid && s_axis_tready;
  assign in_id_wide = WideW'(s_axis_tdata[7:0]);
  assign out_load   = !out_valid_q || m_axis_tready;
  assign fire_any   = |fire_i;
  assign stall      = fire_any && pend_valid_q && !out_load;

  always_comb begin
    fire_id = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      fire_id = fire_id | (cell_id_i[i] & {ID_BITS{fire_i[i]}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q.action <= s_axis_tuser;
      cmd_q.period <= s_axis_tdata[39:8];
      cmd_q.now    <= s_axis_tdata[71:40];
      cmd_id_q     <= in_id_wide[ID_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q   <= pend_id_d;
    fin_found_q <= fin_found_d;
    out_stat_q  <= out_stat_d;
    out_id_q    <= out_id_d;
    out_last_q  <= out_last_d;
  end

  always_comb begin
    state_d      = state_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    fin_found_d  = fin_found_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_stat_d   = out_stat_q;
    out_id_d     = out_id_q;
    out_last_d   = out_last_q;
    s_axis_tready = 1'b0;
    adv_o         = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        adv_o         = 1'b1;
        pend_valid_d  = 1'b0;
        if (s_accept) begin
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        adv_o = !stall;
        if (!stall) begin
          if (fire_any) begin
            // Flush the held fire as a non-final result, hold the new one.
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_stat_d  = STAT_FIRED;
              out_id_d    = pend_id_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_id_d    = fire_id;
          end
          if (tok_last_i) begin
            fin_found_d = found_last_i;
            state_d     = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_id_d    = '0;
          state_d     = S_IDLE;
          case (cmd_q.action) inside
            ACT_TICK: begin
              out_stat_d = pend_valid_q ? STAT_FIRED : STAT_NONE;
              out_id_d   = pend_valid_q ? pend_id_q : '0;
            end
            ACT_ADD:                         out_stat_d = fin_found_q ? STAT_DONE : STAT_FULL;
            ACT_REMOVE, ACT_START, ACT_STOP: out_stat_d = fin_found_q ? STAT_DONE : STAT_MISS;
            default:                         out_stat_d = STAT_MISS;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_id_wide   = WideW'(out_id_q);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_id_wide[ID_FIELD_W-1:0];
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tlast  = out_last_q;
  assign cmd_o         = cmd_q;
  assign cmd_id_o      = cmd_id_q;
  assign launch_o      = s_accept;

  a_fire_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SWEEP) |-> !fire_any)
    else $error("cell fired outside a sweep");

  a_no_pend_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> ((state_q != S_IDLE) || !pend_valid_q))
    else $error("held fire left over in idle");

  a_finish_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FINISH) && out_load) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("final result not presented");

endmodule

FILE: sv/periodic_timer_table_unit.sv
// Top level of the periodic timer table: a chain of ptt_cell slots run by ptt_ctrl.
// Depends on ptt_pkg, ptt_cell and ptt_ctrl.
//
//  channel  dir  signals                       carries
//  s_axis   in   tvalid tready tdata tuser     request: tuser action, tdata id/period/now
//  m_axis   out  tvalid tready tdata tuser     result: tuser status, tdata fired_id,
//                tlast                         tlast marks the last result of a request
//
// With an idle output, each request is accepted, then a token walks the cell chain slot
// by slot, then the final result is posted. A new request is taken only after the final
// result is posted.
// Reset (rst_ni low, asynchronous) empties the table and clears all control state.
// A tick holds back its newest fire until the next one, so tlast can be set correctly;
// the walk stalls while that held fire cannot move into a full result register.
// Any result-side backpressure therefore stretches the walk, never drops a result.
module periodic_timer_table_unit #(
  parameter int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF,
  parameter int ID_BITS     = ptt_pkg::ID_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] handler_id, [39:8] period_ms, [71:40] now_ms
  input  logic [71:0]                   s_axis_tdata,
  // [2:0] action
  input  logic [ptt_pkg::ACT_W-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] fired_id
  output logic [ptt_pkg::ID_FIELD_W-1:0] m_axis_tdata,
  // [2:0] status
  output logic [ptt_pkg::STAT_W-1:0]    m_axis_tuser,
  // last_of_run
  output logic                          m_axis_tlast
);
  import ptt_pkg::*;

  cmd_t               cmd;
  logic [ID_BITS-1:0] cmd_id;
  logic               adv, launch;

  // Per-slot chain wiring.
  logic [TIMER_SLOTS-1:0] tok, found, fire, used, en;
  logic [ID_BITS-1:0]     id     [TIMER_SLOTS];
  logic [TIME_W-1:0]      period [TIMER_SLOTS];
  logic [TIME_W-1:0]      last   [TIMER_SLOTS];

  ptt_ctrl #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .ID_BITS     (ID_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_o         (cmd),
    .cmd_id_o      (cmd_id),
    .adv_o         (adv),
    .launch_o      (launch),
    .fire_i        (fire),
    .cell_id_i     (id),
    .tok_last_i    (tok[TIMER_SLOTS-1]),
    .found_last_i  (found[TIMER_SLOTS-1])
  );

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_slot
    logic              tok_in, found_in, used_r, en_r;
    logic [ID_BITS-1:0] id_r;
    logic [TIME_W-1:0] period_r, last_r;

    if (g == 0) begin : g_head
      // Launch the token with nothing found yet.
      assign tok_in   = launch;
      assign found_in = 1'b0;
    end else begin : g_link
      assign tok_in   = tok[g-1];
      assign found_in = found[g-1];
    end

    if (g == TIMER_SLOTS - 1) begin : g_tail
      // A remove shifts an empty slot into the tail.
      assign used_r   = 1'b0;
      assign id_r     = '0;
      assign period_r = '0;
      assign last_r   = '0;
      assign en_r     = 1'b0;
    end else begin : g_body
      assign used_r   = used[g+1];
      assign id_r     = id[g+1];
      assign period_r = period[g+1];
      assign last_r   = last[g+1];
      assign en_r     = en[g+1];
    end

    ptt_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .cmd_i      (cmd),
      .cmd_id_i   (cmd_id),
      .tok_i      (tok_in),
      .found_i    (found_in),
      .used_r_i   (used_r),
      .id_r_i     (id_r),
      .period_r_i (period_r),
      .last_r_i   (last_r),
      .en_r_i     (en_r),
      .tok_o      (tok[g]),
      .found_o    (found[g]),
      .fire_o     (fire[g]),
      .used_o     (used[g]),
      .id_o       (id[g]),
      .period_o   (period[g]),
      .last_o     (last[g]),
      .en_o       (en[g])
    );
  end

  a_one_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok))
    else $error("more than one token in the chain");

  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (tok == '0))
    else $error("request taken while a token is still walking");

  a_fire_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(fire))
    else $error("two slots fired in one cycle");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for periodic_timer_table_unit: directed and random timer requests.
// Depends on ptt_pkg and the periodic_timer_table_unit RTL; reads no files.
module tb_top;
  import ptt_pkg::*;

  localparam int  SLOTS        = TIMER_SLOTS_DEF;
  localparam int  ID_BITS      = ID_BITS_DEF;
  localparam int  RANDOM_REQS  = 105;
  localparam int  DRAIN_CYCLES = 2 * (SLOTS + 2) + 20;
  localparam int  CYCLE_LIMIT  = 200000;
  localparam int  HOLD_CYCLES  = 400;
  localparam logic [ID_FIELD_W-1:0] ID_MASK = ID_FIELD_W'((1 << ID_BITS) - 1);
  // Action codes past STOP are undefined; the block must answer them with a miss.
  localparam logic [ACT_W-1:0] ACT_FIRST_UNUSED = ACT_W'(ACT_STOP + 1);
  localparam logic [ACT_W-1:0] ACT_LAST_CODE    = '1;

  typedef struct {
    logic [ACT_W-1:0]      action;
    logic [ID_FIELD_W-1:0] handler_id;
    logic [TIME_W-1:0]     period_ms;
    logic [TIME_W-1:0]     now_ms;
  } timer_req_t;

  typedef struct {
    status_e               status;
    logic [ID_FIELD_W-1:0] fired_id;
    logic                  last_of_run;
  } timer_result_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [71:0]            s_axis_tdata  = '0;
  logic [ACT_W-1:0]       s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [ID_FIELD_W-1:0]  m_axis_tdata;
  logic [STAT_W-1:0]      m_axis_tuser;
  logic                   m_axis_tlast;

  periodic_timer_table_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Requests waiting for the driver, and the results the timer table must still post.
  timer_req_t    timer_reqs_pending[$];
  timer_result_t expected_results[$];
  int            fail_count = 0;

  // Shadow of the timer table, advanced once per accepted request.
  logic                  slot_used    [SLOTS];
  logic [ID_FIELD_W-1:0] slot_id      [SLOTS];
  logic [TIME_W-1:0]     slot_period  [SLOTS];
  logic [TIME_W-1:0]     slot_stamp   [SLOTS];
  logic                  slot_enabled [SLOTS];

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
    end
  end

  // Ids the generator believes live in the table, in table order; lets it aim
  // remove/start/stop at real entries.
  logic [ID_FIELD_W-1:0] live_ids[$];
  logic [TIME_W-1:0]     gen_now;

  function automatic int find_timer_slot(logic [ID_FIELD_W-1:0] key);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_id[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void expect_result(status_e st, logic [ID_FIELD_W-1:0] id, logic last);
    timer_result_t r;
    r.status      = st;
    r.fired_id    = id;
    r.last_of_run = last;
    expected_results.push_back(r);
  endfunction

  // Apply one accepted request to the shadow table and queue the results it causes.
  function automatic void predict_timer_results(timer_req_t req);
    logic [ID_FIELD_W-1:0] key;
    logic [ID_FIELD_W-1:0] fired[SLOTS];
    logic [TIME_W-1:0]     elapsed;
    int                    n_fired;
    int                    n_used;
    int                    hit;
    key     = req.handler_id & ID_MASK;
    n_fired = 0;
    n_used  = 0;
    case (req.action) inside
      ACT_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          elapsed = req.now_ms - slot_stamp[i];
          if (slot_used[i] && slot_enabled[i] && elapsed >= slot_period[i]) begin
            slot_stamp[i]  = req.now_ms;
            fired[n_fired] = slot_id[i];
            n_fired++;
          end
        end
        if (n_fired == 0) begin
          expect_result(STAT_NONE, '0, 1'b1);
        end else begin
          for (int k = 0; k < n_fired; k++) begin
            expect_result(STAT_FIRED, fired[k], k == n_fired - 1);
          end
        end
      end
      ACT_ADD: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i]) n_used++;
        end
        if (n_used >= SLOTS) begin
          expect_result(STAT_FULL, '0, 1'b1);
        end else begin
          slot_used[n_used]    = 1'b1;
          slot_id[n_used]      = key;
          slot_period[n_used]  = req.period_ms;
          slot_stamp[n_used]   = req.now_ms;
          slot_enabled[n_used] = 1'b1;
          expect_result(STAT_DONE, '0, 1'b1);
        end
      end
      ACT_REMOVE: begin
        hit = find_timer_slot(key);
        if (hit < 0) begin
          expect_result(STAT_MISS, '0, 1'b1);
        end else begin
          // Close the gap, keeping the later entries in order.
          for (int i = hit; i + 1 < SLOTS; i++) begin
            slot_used[i]    = slot_used[i + 1];
            slot_id[i]      = slot_id[i + 1];
            slot_period[i]  = slot_period[i + 1];
            slot_stamp[i]   = slot_stamp[i + 1];
            slot_enabled[i] = slot_enabled[i + 1];
          end
          slot_used[SLOTS - 1] = 1'b0;
          expect_result(STAT_DONE, '0, 1'b1);
        end
      end
      ACT_START, ACT_STOP: begin
        hit = find_timer_slot(key);
        if (hit < 0) begin
          expect_result(STAT_MISS, '0, 1'b1);
        end else begin
          slot_enabled[hit] = (req.action == ACT_START);
          expect_result(STAT_DONE, '0, 1'b1);
        end
      end
      default: begin
        expect_result(STAT_MISS, '0, 1'b1);
      end
    endcase
  endfunction

  // Queue a request and keep the generator's view of live ids in step.
  function automatic void queue_timer_req(logic [ACT_W-1:0] act, logic [ID_FIELD_W-1:0] id,
                                          logic [TIME_W-1:0] period, logic [TIME_W-1:0] now);
    timer_req_t req;
    req.action     = act;
    req.handler_id = id;
    req.period_ms  = period;
    req.now_ms     = now;
    timer_reqs_pending.push_back(req);
    if (act == ACT_ADD && live_ids.size() < SLOTS) begin
      live_ids.push_back(id & ID_MASK);
    end else if (act == ACT_REMOVE) begin
      for (int i = 0; i < live_ids.size(); i++) begin
        if (live_ids[i] == (id & ID_MASK)) begin
          live_ids.delete(i);
          break;
        end
      end
    end
  endfunction

  function automatic logic [ID_FIELD_W-1:0] pick_target_id();
    if (live_ids.size() > 0 && $urandom_range(0, 99) < 85) begin
      return live_ids[$urandom_range(0, live_ids.size() - 1)];
    end
    if ($urandom_range(0, 1)) return ID_FIELD_W'($urandom_range(0, 7));
    return ID_FIELD_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [TIME_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 55) return $urandom_range(1, 8);
    if (r < 80) return $urandom_range(0, 64);
    if (r < 90) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(0, 16);
  endfunction

  // Advance the free-running millisecond time; now and then jump or wrap.
  function automatic void advance_now();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)      gen_now = gen_now + $urandom_range(0, 6);
    else if (r < 90) gen_now = gen_now + $urandom_range(0, 40);
    else if (r < 95) gen_now = gen_now + $urandom;
    else             gen_now = 32'hFFFF_FFFF - $urandom_range(0, 64);
  endfunction

  // Driver: offer queued requests in bursts with random gaps in between.
  timer_req_t cur_req;
  int         burst_left;
  int         gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_timer_results(cur_req);
      // Hold the offered request until it is taken.
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (timer_reqs_pending.size() > 0) begin
          cur_req = timer_reqs_pending.pop_front();
          s_axis_tdata  <= {cur_req.now_ms, cur_req.period_ms, cur_req.handler_id};
          s_axis_tuser  <= cur_req.action;
          s_axis_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall on phases of its own; twice it holds off for a long stretch so the
  // result side backs up into the request side.
  int rx_cycle;
  int hold_left;
  int phase_left;
  int phase_mode;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_cycle   = 0;
      hold_left  = 0;
      phase_left = 0;
      phase_mode = 0;
    end else begin
      rx_cycle++;
      if (rx_cycle == 1500 || rx_cycle == 3500) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (phase_left <= 0) begin
          phase_mode = $urandom_range(0, 3);
          phase_left = $urandom_range(20, 200);
        end
        phase_left--;
        case (phase_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= (rx_cycle % 4 == 0);
          default: m_axis_tready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // Monitor: compare each posted result with the oldest expectation.
  always @(posedge clk_i) begin
    timer_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d fired_id %0d last_of_run %0d",
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata !== want.fired_id) begin
          $error("fired_id: expected %0d, actual %0d", want.fired_id, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.last_of_run) begin
          $error("last_of_run: expected %0d, actual %0d", want.last_of_run, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  int cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int rand_reqs;
    int episode_len;
    int mode;
    int r;
    logic [ACT_W-1:0] act;

    // Directed: empty table, misses, id and time extremes, wrap, zero and maximum
    // interval, stop/start, duplicate ids, remove from the middle, undefined actions.
    queue_timer_req(ACT_TICK,   8'd0,   '0, 32'h0000_0000);
    queue_timer_req(ACT_REMOVE, 8'd0,   '0, 32'h0000_0000);
    queue_timer_req(ACT_START,  8'd0,   '0, 32'h0000_0000);
    queue_timer_req(ACT_STOP,   8'd255, '0, 32'h0000_0000);
    queue_timer_req(ACT_ADD,    8'd0,   32'h0000_0000, 32'hFFFF_FFFF);
    queue_timer_req(ACT_ADD,    8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_timer_req(ACT_ADD,    8'd7,   32'h0000_0020, 32'hFFFF_FFFF);
    queue_timer_req(ACT_TICK,   8'd0,   '0, 32'h0000_0007);
    queue_timer_req(ACT_TICK,   8'd0,   '0, 32'h0000_001F);
    queue_timer_req(ACT_STOP,   8'd0,   '0, 32'h0000_001F);
    queue_timer_req(ACT_TICK,   8'd0,   '0, 32'h0000_0020);
    queue_timer_req(ACT_TICK,   8'd0,   '0, 32'h0000_0040);
    queue_timer_req(ACT_START,  8'd0,   '0, 32'h0000_0040);
    queue_timer_req(ACT_TICK,   8'd0,   '0, 32'h0000_0041);
    queue_timer_req(ACT_ADD,    8'd7,   32'h0000_0001, 32'h0000_0041);
    queue_timer_req(ACT_STOP,   8'd7,   '0, 32'h0000_0041);
    queue_timer_req(ACT_TICK,   8'd0,   '0, 32'h0000_0080);
    queue_timer_req(ACT_REMOVE, 8'd255, '0, 32'h0000_0080);
    queue_timer_req(ACT_REMOVE, 8'd7,   '0, 32'h0000_0080);
    queue_timer_req(ACT_TICK,   8'd0,   '0, 32'h0000_0081);
    for (int a = ACT_FIRST_UNUSED; a <= ACT_LAST_CODE; a++) begin
      queue_timer_req(ACT_W'(a), 8'd0, '0, 32'h0000_0081);
    end
    queue_timer_req(ACT_REMOVE, 8'd0,   '0, 32'h0000_0081);
    queue_timer_req(ACT_REMOVE, 8'd7,   '0, 32'h0000_0081);

    // Random: episodes that fill the table, drain it, or mix every action.
    gen_now   = 32'h0000_0100;
    rand_reqs = 0;
    while (rand_reqs < RANDOM_REQS) begin
      mode        = $urandom_range(0, 2);
      episode_len = $urandom_range(10, 30);
      for (int k = 0; k < episode_len && rand_reqs < RANDOM_REQS; k++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0:       act = (r < 55) ? ACT_ADD : (r < 85) ? ACT_TICK :
                         (r < 92) ? ACT_STOP : ACT_START;
          1:       act = (r < 45) ? ACT_REMOVE : (r < 75) ? ACT_TICK :
                         (r < 83) ? ACT_START : (r < 90) ? ACT_STOP : ACT_ADD;
          default: act = (r < 35) ? ACT_TICK : (r < 55) ? ACT_ADD :
                         (r < 70) ? ACT_REMOVE : (r < 82) ? ACT_START :
                         (r < 94) ? ACT_STOP :
                         ACT_W'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_CODE));
        endcase
        advance_now();
        if (act == ACT_ADD) begin
          queue_timer_req(act, $urandom_range(0, 1) ? ID_FIELD_W'($urandom_range(0, 7))
                                                    : ID_FIELD_W'($urandom_range(0, 255)),
                          pick_period(), gen_now);
        end else if (act == ACT_TICK) begin
          // Period and id are don't-care here; fill them with noise anyway.
          queue_timer_req(act, ID_FIELD_W'($urandom_range(0, 255)), $urandom, gen_now);
        end else begin
          queue_timer_req(act, pick_target_id(), $urandom, gen_now);
        end
        rand_reqs++;
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to be taken and every result to arrive, then drain.
    while (timer_reqs_pending.size() > 0 || s_axis_tvalid || expected_results.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/ptt_pkg.sv
sv/ptt_cell.sv
sv/ptt_ctrl.sv
sv/periodic_timer_table_unit.sv
verif/tb_top.sv
